// File: rtl/cbi_pkg.sv
package cbi_pkg;

  localparam int unsigned CrcWidth   = 32;
  localparam int unsigned BucketWidth = 31;
  localparam int unsigned ChunkBytes = 8;

  localparam logic [CrcWidth-1:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] CrcPoly = 32'h82F6_3B78;
  localparam logic [BucketWidth-1:0] BucketReset = 31'd1024;

  // Columns of a linear map: entry t is the image of input bit t.
  typedef logic [7:0][CrcWidth-1:0]          byte_cols_t;
  typedef logic [CrcWidth-1:0][CrcWidth-1:0] word_cols_t;

  // Request handed from the CRC front end to the divider.
  typedef struct packed {
    logic                   start;
    logic [CrcWidth-1:0]    crc;
    logic [BucketWidth-1:0] divisor;
  } cbi_div_req_t;

  // Runs the reflected CRC shift register over nbits zero input bits.
  // Only evaluated at elaboration to build constant XOR matrices.
  function automatic logic [CrcWidth-1:0] crc_steps(logic [CrcWidth-1:0] c,
                                                    int unsigned nbits);
    logic [CrcWidth-1:0] r;
    r = c;
    for (int unsigned i = 0; i < nbits; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  // Effect of one data byte followed by nzero zero bytes, starting from zero.
  function automatic byte_cols_t lane_cols(int unsigned nzero);
    byte_cols_t cols;
    for (int unsigned t = 0; t < 8; t++) begin
      cols[t] = crc_steps(32'h1 << t, 8 * (nzero + 1));
    end
    return cols;
  endfunction

  // Effect of nbytes bytes on the running CRC state alone.
  function automatic word_cols_t word_cols(int unsigned nbytes);
    word_cols_t cols;
    for (int unsigned t = 0; t < CrcWidth; t++) begin
      cols[t] = crc_steps(32'h1 << t, 8 * nbytes);
    end
    return cols;
  endfunction

endpackage

// File: rtl/crc32c_bucket_index.sv
// Streaming CRC-32C key hash with bucket selection.
// Keys arrive on the s_axis channel as chunks of up to eight bytes, the first
// byte in the lowest bits, with a count of valid bytes and tlast on the final
// chunk of each key. An empty key is one tlast chunk with a count of zero.
// Each key yields one request on m_axis carrying the raw reflected CRC-32C
// (all-ones start, no final inversion) and that CRC modulo bucket_count.
// Chunks that are not last are taken one per cycle; the lanes fold a whole
// chunk into the CRC register in the cycle that it is taken.
// A last chunk hands its CRC to a restoring divider that produces one quotient
// bit per cycle, but for a final step that can wait on the output register.
// While the divider is busy, a further last chunk is held off (tready low), so no
// key end is taken before the divider is done with the last; chunks that are not
// last of the next key still flow meanwhile. A finished result waits in the
// output register while the receiver stalls, and the divider may already start
// on the next key; it only holds its final step until the output register is free.
// Reset loads the CRC with all ones, sets bucket_count to 1024 and empties
// the divider and the output register. A bucket_count of zero gives index 0.
// The user writes bucket_count with cfg_we_i only while no key is in flight; the block does not enforce it.
module crc32c_bucket_index #(
  parameter int unsigned LANES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // key_bytes[63:0], byte_count[67:64], zero fill
  input  logic        s_axis_tlast,   // key_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // bucket_index[30:0], crc_value[62:31], zero fill
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i     // bucket_count
);

  logic                            accept;
  logic                            div_busy;
  logic [cbi_pkg::BucketWidth-1:0] bucket_count_q;
  logic [cbi_pkg::CrcWidth-1:0]    crc_next;
  cbi_pkg::cbi_div_req_t           div_req;
  logic [cbi_pkg::BucketWidth-1:0] out_bucket;
  logic [cbi_pkg::CrcWidth-1:0]    out_crc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= cbi_pkg::BucketReset;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  // Only the last chunk of a key needs the divider.
  assign s_axis_tready = !s_axis_tlast || !div_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cbi_crc #(
    .LANES(LANES)
  ) u_crc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .key_bytes_i (s_axis_tdata[63:0]),
    .byte_count_i(s_axis_tdata[67:64]),
    .key_end_i   (s_axis_tlast),
    .crc_next_o  (crc_next)
  );

  assign div_req.start   = accept && s_axis_tlast;
  assign div_req.crc     = crc_next;
  assign div_req.divisor = bucket_count_q;

  cbi_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .busy_o      (div_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_bucket_o(out_bucket),
    .out_crc_o   (out_crc)
  );

  assign m_axis_tdata = {1'b0, out_crc, out_bucket};

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s_axis_tlast && div_busy)
    else $error("Input stalled without a pending key end");

endmodule

// File: rtl/cbi_lane.sv
// One byte lane: the CRC contribution of its byte, advanced over the bytes
// that follow it in the chunk.
module cbi_lane #(
  parameter int unsigned ZeroBytes = 0
) (
  input  logic [7:0]                   byte_i,
  output logic [cbi_pkg::CrcWidth-1:0] contrib_o
);

  localparam cbi_pkg::byte_cols_t Cols = cbi_pkg::lane_cols(ZeroBytes);

  always_comb begin
    contrib_o = '0;
    for (int unsigned t = 0; t < 8; t++) begin
      if (byte_i[t]) begin
        contrib_o = contrib_o ^ Cols[t];
      end
    end
  end

endmodule

// File: rtl/cbi_crc.sv
// CRC front end: aligns the valid bytes to the top lanes, runs the lanes and
// merges their contributions with the advanced running CRC.
module cbi_crc #(
  parameter int unsigned LANES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [63:0]                  key_bytes_i,
  input  logic [3:0]                   byte_count_i,
  input  logic                         key_end_i,
  output logic [cbi_pkg::CrcWidth-1:0] crc_next_o
);

  localparam int unsigned CntW = $clog2(LANES + 1);

  logic [CntW-1:0]                  n_bytes;
  logic [CntW-1:0]                  shift_bytes;
  logic [63:0]                      aligned;
  logic [cbi_pkg::CrcWidth-1:0]     crc_q, crc_d;
  logic [cbi_pkg::CrcWidth-1:0]     adv [LANES+1];
  logic [cbi_pkg::CrcWidth-1:0]     contrib [LANES];
  logic [cbi_pkg::CrcWidth-1:0]     lanes_x;

  assign n_bytes     = (byte_count_i > 4'(LANES)) ? CntW'(LANES) : CntW'(byte_count_i);
  assign shift_bytes = CntW'(LANES) - n_bytes;
  // Valid bytes end up in the top lanes; unused low lanes see zero bytes.
  assign aligned     = key_bytes_i << {shift_bytes, 3'b000};

  for (genvar n = 0; n <= LANES; n++) begin : g_adv
    localparam cbi_pkg::word_cols_t AdvCols = cbi_pkg::word_cols(n);
    always_comb begin
      adv[n] = '0;
      for (int unsigned t = 0; t < cbi_pkg::CrcWidth; t++) begin
        if (crc_q[t]) begin
          adv[n] = adv[n] ^ AdvCols[t];
        end
      end
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    cbi_lane #(
      .ZeroBytes(LANES - 1 - j)
    ) u_lane (
      .byte_i   (aligned[8*j +: 8]),
      .contrib_o(contrib[j])
    );
  end

  always_comb begin
    lanes_x = '0;
    for (int unsigned j = 0; j < LANES; j++) begin
      lanes_x = lanes_x ^ contrib[j];
    end
  end

  assign crc_next_o = adv[n_bytes] ^ lanes_x;
  assign crc_d      = key_end_i ? cbi_pkg::CrcInit : crc_next_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= cbi_pkg::CrcInit;
    end else if (accept_i) begin
      crc_q <= crc_d;
    end
  end

  a_reload_after_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && key_end_i |=> crc_q == cbi_pkg::CrcInit)
    else $error("CRC not reloaded after the last chunk of a key");

endmodule

// File: rtl/cbi_div.sv
// Restoring divider, one quotient bit per cycle but for a final step held until its own result register is free.
module cbi_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cbi_pkg::cbi_div_req_t           req_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cbi_pkg::BucketWidth-1:0] out_bucket_o,
  output logic [cbi_pkg::CrcWidth-1:0]    out_crc_o
);

  localparam int unsigned CntW = $clog2(cbi_pkg::CrcWidth);

  logic                            busy_q;
  logic [CntW-1:0]                 cnt_q;
  logic [cbi_pkg::CrcWidth-1:0]    dvd_q;
  logic [cbi_pkg::BucketWidth-1:0] rem_q, rem_d;
  logic [cbi_pkg::BucketWidth-1:0] dvs_q;
  logic [cbi_pkg::CrcWidth-1:0]    crc_q;
  logic                            out_valid_q;
  logic [cbi_pkg::BucketWidth-1:0] out_bucket_q;
  logic [cbi_pkg::CrcWidth-1:0]    out_crc_q;
  logic [cbi_pkg::CrcWidth-1:0]    trial;
  logic [cbi_pkg::CrcWidth-1:0]    diff;
  logic                            fits;
  logic                            last_step;
  logic                            slot_free;
  logic                            step;

  assign trial     = {rem_q, dvd_q[cbi_pkg::CrcWidth-1]};
  assign diff      = trial - {1'b0, dvs_q};
  assign fits      = trial >= {1'b0, dvs_q};
  assign rem_d     = fits ? diff[cbi_pkg::BucketWidth-1:0] : trial[cbi_pkg::BucketWidth-1:0];
  assign last_step = cnt_q == CntW'(cbi_pkg::CrcWidth - 1);
  assign slot_free = !out_valid_q || out_ready_i;
  // The final step waits until the result register can take its value.
  assign step      = busy_q && (!last_step || slot_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
      if (step && last_step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.crc;
      crc_q <= req_i.crc;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
    if (step && last_step) begin
      out_bucket_q <= (dvs_q == '0) ? '0 : rem_d;
      out_crc_q    <= crc_q;
    end
  end

  assign busy_o       = busy_q;
  assign out_valid_o  = out_valid_q;
  assign out_bucket_o = out_bucket_q;
  assign out_crc_o    = out_crc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("Divider started while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && $past(busy_q) && dvs_q != '0 |-> rem_q < dvs_q)
    else $error("Partial remainder not below the divisor");

  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last_step && dvs_q != '0 |=> out_bucket_q < $past(dvs_q))
    else $error("Bucket index not below the bucket count");

endmodule
